/* rtl/core/bfr_pkg.sv */
// ----------------------------------------------------------------------------
// bfr_pkg: shared constants and types of the text overlay renderer
// Font and string store geometry, GB2312 code constants, command codes and
// the structures that pass between the string walker and the glyph unit.
// ----------------------------------------------------------------------------
package bfr_pkg;

  localparam int STRING_BYTES = 128;
  localparam int GLYPH_WIDTH  = 24;
  localparam int GLYPH_HEIGHT = 30;
  localparam int FONT_BYTES   = 1048576;
  localparam int GLYPH_BYTES  = GLYPH_WIDTH * GLYPH_HEIGHT / 8;

  localparam int CMD_W     = 2;
  localparam int LOAD_AW   = 20;
  localparam int ROW_W     = 5;
  localparam int COL_W     = 12;
  localparam int COLOR_W   = 16;
  localparam int COL_MAX   = (1 << COL_W) - 1;

  localparam int FONT_AW   = $clog2(FONT_BYTES);
  localparam int STR_AW    = $clog2(STRING_BYTES);
  localparam int STR_CW    = $clog2(STRING_BYTES + 1);
  localparam int WANT_W    = $clog2(COL_MAX / GLYPH_WIDTH + 1);
  localparam int CNT_W     = (WANT_W > STR_CW) ? WANT_W : STR_CW;
  localparam int CCOL_W    = $clog2(GLYPH_WIDTH);

  localparam int HEX_W     = 12;
  localparam int INDEX_W   = 16;
  localparam int ADDR_CW   = 25;

  localparam int RECIP_SHIFT = 24;
  localparam int GW_RECIP    = (1 << RECIP_SHIFT) / GLYPH_WIDTH;
  localparam int DIV_PROD_W  = 36;

  localparam logic [COLOR_W-1:0] TEXT_COLOR_RST       = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BACKGROUND_COLOR_RST = 16'h8000;

  localparam logic [INDEX_W-1:0] ROW_CODES  = 16'd94;
  localparam logic [INDEX_W-1:0] AREA_ASCII = 16'd3;
  localparam logic [7:0]         CODE_BASE  = 8'hA0;
  localparam logic [7:0]         ASCII_BASE = 8'h20;
  localparam logic [7:0]         ASCII_MAX  = 8'h7F;
  localparam logic [7:0]         LEAD_MIN   = 8'h80;

  typedef enum logic [CMD_W-1:0] {
    CMD_FONT   = 2'd0,
    CMD_STRING = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_TEXT_COLOR       = 1'b0,
    REG_BACKGROUND_COLOR = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic       found;
    logic [7:0] b0;
    logic [7:0] b1;
  } walk_res_t;

  typedef struct packed {
    logic              found;
    logic [7:0]        b0;
    logic [7:0]        b1;
    logic [ROW_W-1:0]  row;
    logic [CCOL_W-1:0] ccol;
  } query_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               in_text;
    logic               err;
  } pix_t;

endpackage

/* rtl/core/bfr_ram.sv */
// ----------------------------------------------------------------------------
// bfr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module bfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/bfr_walk.sv */
// ----------------------------------------------------------------------------
// bfr_walk: string store and character walker
// Holds the string bytes with per-entry valid bits and scans them one byte
// a cycle to find the lead byte (and trail byte) of a display character.
// ----------------------------------------------------------------------------
module bfr_walk import bfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [STR_AW-1:0] wr_addr,
  input  logic [7:0]        wr_byte,
  input  logic              start,
  input  logic [CNT_W-1:0]  want,
  output logic              done,
  output walk_res_t         res
);

  typedef enum logic [2:0] {
    W_IDLE  = 3'b001,
    W_SCAN  = 3'b010,
    W_TRAIL = 3'b100
  } wstate_t;

  wstate_t             state_r, state_nxt;
  logic [STR_CW-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]    chars_r, chars_nxt;
  logic [CNT_W-1:0]    want_r, want_nxt;
  logic                pair_r, pair_nxt;
  logic                done_r, done_nxt;
  walk_res_t           res_r, res_nxt;
  logic [STRING_BYTES-1:0] valid_r;
  logic                vld_r;

  logic [STR_CW-1:0]   idx_inc;
  logic                last;
  logic                re;
  logic [STR_AW-1:0]   raddr;
  logic [7:0]          rdata;
  logic [7:0]          byte_v;

  assign idx_inc = idx_r + 1'b1;
  assign last    = (idx_inc == STR_CW'(STRING_BYTES));
  assign re      = start || (state_r == W_SCAN);
  assign raddr   = (state_r != W_SCAN || last) ? '0 : idx_inc[STR_AW-1:0];
  assign byte_v  = vld_r ? rdata : 8'h00;

  bfr_ram #(
    .WIDTH (8),
    .DEPTH (STRING_BYTES)
  ) u_str_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_byte),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    chars_nxt = chars_r;
    want_nxt  = want_r;
    pair_nxt  = pair_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    case (state_r)
      W_IDLE: begin
        if (start) begin
          idx_nxt   = '0;
          chars_nxt = '0;
          pair_nxt  = 1'b0;
          want_nxt  = want;
          res_nxt   = '0;
          state_nxt = W_SCAN;
        end
      end
      W_SCAN: begin
        if (byte_v == 8'h00) begin
          res_nxt.found = 1'b0;
          done_nxt      = 1'b1;
          state_nxt     = W_IDLE;
        end else if (pair_r) begin
          pair_nxt = 1'b0;
          idx_nxt  = idx_inc;
          if (last) begin
            res_nxt.found = 1'b0;
            done_nxt      = 1'b1;
            state_nxt     = W_IDLE;
          end
        end else if (chars_r == want_r) begin
          res_nxt.found = 1'b1;
          res_nxt.b0    = byte_v;
          res_nxt.b1    = 8'h00;
          if (byte_v < LEAD_MIN || last) begin
            done_nxt  = 1'b1;
            state_nxt = W_IDLE;
          end else begin
            state_nxt = W_TRAIL;
          end
        end else begin
          chars_nxt = chars_r + 1'b1;
          pair_nxt  = (byte_v >= LEAD_MIN);
          idx_nxt   = idx_inc;
          if (last) begin
            res_nxt.found = 1'b0;
            done_nxt      = 1'b1;
            state_nxt     = W_IDLE;
          end
        end
      end
      W_TRAIL: begin
        res_nxt.b1 = byte_v;
        done_nxt   = 1'b1;
        state_nxt  = W_IDLE;
      end
      default: begin
        state_nxt = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
      done_r  <= 1'b0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    chars_r <= chars_nxt;
    want_r  <= want_nxt;
    pair_r  <= pair_nxt;
    res_r   <= res_nxt;
    if (re) begin
      vld_r <= valid_r[raddr];
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

/* rtl/core/bfr_glyph.sv */
// ----------------------------------------------------------------------------
// bfr_glyph: glyph address, font store and colour select
// Works out the glyph byte address of a found character, reads the font
// store and picks text or background colour; holds the result until taken.
// ----------------------------------------------------------------------------
module bfr_glyph import bfr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               font_we,
  input  logic [FONT_AW-1:0] font_waddr,
  input  logic [7:0]         font_wbyte,
  input  logic               start,
  input  query_t             query,
  input  logic [COLOR_W-1:0] text_color,
  input  logic [COLOR_W-1:0] background_color,
  output logic               res_valid,
  input  logic               res_take,
  output pix_t               res
);

  typedef enum logic [4:0] {
    G_IDLE  = 5'b00001,
    G_INDEX = 5'b00010,
    G_ADDR  = 5'b00100,
    G_READ  = 5'b01000,
    G_DONE  = 5'b10000
  } gstate_t;

  gstate_t              state_r;
  query_t               q_r;
  logic [INDEX_W-1:0]   index_r;
  logic [HEX_W-1:0]     hex_r;
  logic [ADDR_CW-1:0]   addr_r;
  logic                 err_r;

  logic                 ascii;
  logic [INDEX_W-1:0]   area;
  logic [INDEX_W-1:0]   code;
  logic [INDEX_W-1:0]   index_c;
  logic [HEX_W-1:0]     hex_c;
  logic                 font_re;
  logic [7:0]           font_rdata;
  logic                 bit_on;
  logic                 row_out;

  assign ascii   = (q_r.b0 <= ASCII_MAX);
  assign area    = ascii ? AREA_ASCII : {8'h00, q_r.b0} - {8'h00, CODE_BASE};
  assign code    = ascii ? {8'h00, q_r.b0} - {8'h00, ASCII_BASE}
                         : {8'h00, q_r.b1} - {8'h00, CODE_BASE};
  assign index_c = INDEX_W'(ROW_CODES * (area - 16'd1)) + code - 16'd1;
  assign hex_c   = HEX_W'((32'(q_r.row) * GLYPH_WIDTH) >> 3)
                 + HEX_W'(q_r.ccol >> 3);

  assign font_re = (state_r == G_READ);

  bfr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_BYTES)
  ) u_font_ram (
    .clk   (clk),
    .we    (font_we),
    .waddr (font_waddr),
    .wdata (font_wbyte),
    .re    (font_re),
    .raddr (addr_r[FONT_AW-1:0]),
    .rdata (font_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
    end else begin
      case (state_r)
        G_IDLE:  if (start) state_r <= G_INDEX;
        G_INDEX: state_r <= G_ADDR;
        G_ADDR:  state_r <= G_READ;
        G_READ:  state_r <= G_DONE;
        G_DONE:  if (res_take) state_r <= G_IDLE;
        default: state_r <= G_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      G_IDLE: begin
        if (start) begin
          q_r <= query;
        end
      end
      G_INDEX: begin
        index_r <= index_c;
        hex_r   <= hex_c;
      end
      G_ADDR: begin
        addr_r <= ADDR_CW'(32'(index_r[INDEX_W-2:0]) * GLYPH_BYTES) + ADDR_CW'(hex_r);
        err_r  <= index_r[INDEX_W-1] || (32'(hex_r) >= 32'(GLYPH_BYTES));
      end
      G_READ: begin
        err_r <= err_r || (addr_r >= ADDR_CW'(FONT_BYTES));
      end
      default: begin
      end
    endcase
  end

  assign bit_on  = font_rdata[3'd7 - q_r.ccol[2:0]];
  assign row_out = (32'(q_r.row) >= 32'(GLYPH_HEIGHT));

  always_comb begin
    res.color   = background_color;
    res.in_text = q_r.found;
    res.err     = 1'b0;
    if (q_r.found && !row_out) begin
      if (err_r) begin
        res.err = 1'b1;
      end else if (bit_on) begin
        res.color = text_color;
      end
    end
  end

  assign res_valid = (state_r == G_DONE);

endmodule

/* rtl/core/bitmap_font_text_pixel_renderer.sv */
// ----------------------------------------------------------------------------
// bitmap_font_text_pixel_renderer: text overlay pixel renderer
// Font and string loads, GB2312/ASCII character walk and glyph bit lookup.
// ----------------------------------------------------------------------------
// Loads give no result; one may follow every cycle while no query is in flight.
// A pixel query splits the column into character and glyph column, then the
// string walk reads one store byte per cycle, up to STRING_BYTES bytes,
// then four glyph steps look up the glyph bit.
// One query is in flight at a time; the next transfer is taken on return.
// Reset empties the string store at once, sets the colours to their defaults
// and leaves the font store undefined until written.
// ----------------------------------------------------------------------------
module bitmap_font_text_pixel_renderer import bfr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [LOAD_AW-1:0] in_load_address,
  input  logic [7:0]         in_load_byte,
  input  logic [ROW_W-1:0]   in_pixel_row,
  input  logic [COL_W-1:0]   in_pixel_col,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COLOR_W-1:0] out_pixel_color,
  output logic               out_inside_text,
  output logic               out_font_error,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [COLOR_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_REM   = 5'b00100,
    S_WALK  = 5'b01000,
    S_GLYPH = 5'b10000
  } state_t;

  state_t             state_r;
  logic [COLOR_W-1:0] text_color_r;
  logic [COLOR_W-1:0] background_color_r;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;
  logic [CNT_W-1:0]   q0_r;
  logic [CCOL_W-1:0]  ccol_r;
  logic               out_valid_r;
  pix_t               out_pix_r;

  logic               accept;
  cmd_t               cmd;
  logic [DIV_PROD_W-1:0] div_prod;
  logic [COL_W-1:0]   rem_raw;
  logic [CNT_W-1:0]   want_c;
  logic [CCOL_W-1:0]  ccol_c;
  logic               str_we;
  logic               font_we;
  logic               walk_start;
  logic               walk_done;
  walk_res_t          walk_res;
  logic               glyph_start;
  query_t             glyph_query;
  logic               glyph_res_valid;
  logic               glyph_take;
  pix_t               glyph_res;
  logic               out_free;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cmd      = cmd_t'(in_command);

  assign str_we  = accept && (cmd == CMD_STRING)
                && (32'(in_load_address) < 32'(STRING_BYTES));
  assign font_we = accept && (cmd == CMD_FONT)
                && (32'(in_load_address) < 32'(FONT_BYTES));

  assign div_prod = DIV_PROD_W'(col_r) * DIV_PROD_W'(GW_RECIP);
  assign rem_raw  = col_r - COL_W'(32'(q0_r) * GLYPH_WIDTH);

  always_comb begin
    if (32'(rem_raw) >= 32'(GLYPH_WIDTH)) begin
      want_c = q0_r + 1'b1;
      ccol_c = CCOL_W'(32'(rem_raw) - 32'(GLYPH_WIDTH));
    end else begin
      want_c = q0_r;
      ccol_c = CCOL_W'(rem_raw);
    end
  end

  assign walk_start = (state_r == S_REM);
  assign out_free   = !out_valid_r || !out_stall;
  assign glyph_take = (state_r == S_GLYPH) && glyph_res_valid && out_free;
  assign glyph_start = (state_r == S_WALK) && walk_done;

  always_comb begin
    glyph_query.found = walk_res.found;
    glyph_query.b0    = walk_res.b0;
    glyph_query.b1    = walk_res.b1;
    glyph_query.row   = row_r;
    glyph_query.ccol  = ccol_r;
  end

  bfr_walk u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (str_we),
    .wr_addr (in_load_address[STR_AW-1:0]),
    .wr_byte (in_load_byte),
    .start   (walk_start),
    .want    (want_c),
    .done    (walk_done),
    .res     (walk_res)
  );

  bfr_glyph u_glyph (
    .clk              (clk),
    .rst_n            (rst_n),
    .font_we          (font_we),
    .font_waddr       (FONT_AW'(in_load_address)),
    .font_wbyte       (in_load_byte),
    .start            (glyph_start),
    .query            (glyph_query),
    .text_color       (text_color_r),
    .background_color (background_color_r),
    .res_valid        (glyph_res_valid),
    .res_take         (glyph_take),
    .res              (glyph_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      text_color_r       <= TEXT_COLOR_RST;
      background_color_r <= BACKGROUND_COLOR_RST;
      out_valid_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_TEXT_COLOR:       text_color_r       <= cfg_data;
          REG_BACKGROUND_COLOR: background_color_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (glyph_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE:  if (accept && cmd == CMD_QUERY) state_r <= S_DIV;
        S_DIV:   state_r <= S_REM;
        S_REM:   state_r <= S_WALK;
        S_WALK:  if (walk_done) state_r <= S_GLYPH;
        S_GLYPH: if (glyph_take) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_r <= in_pixel_col;
      row_r <= in_pixel_row;
    end
    if (state_r == S_DIV) begin
      q0_r <= div_prod[RECIP_SHIFT +: CNT_W];
    end
    if (state_r == S_REM) begin
      ccol_r <= ccol_c;
    end
    if (glyph_take) begin
      out_pix_r <= glyph_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_pix_r.color;
  assign out_inside_text = out_pix_r.in_text;
  assign out_font_error  = out_pix_r.err;

  a_walk_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    walk_done |-> state_r == S_WALK)
    else $error("walk done outside walk phase");

  a_glyph_valid_in_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    glyph_res_valid |-> state_r == S_GLYPH)
    else $error("glyph result outside glyph phase");

  a_out_from_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(glyph_take))
    else $error("result appeared without a glyph transfer");

  a_outside_is_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pix_r.in_text |-> !out_pix_r.err
      && out_pix_r.color == background_color_r)
    else $error("pixel beyond text not background");

  a_error_is_background: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pix_r.err |-> out_pix_r.in_text
      && out_pix_r.color == background_color_r)
    else $error("font error pixel not background");

endmodule
